@@ hdl/plhc_pkg.sv @@
// ----------------------------------------------------------------------------
// plhc_pkg
// Shared types, thresholds and helpers for the pressure level controller.
// ----------------------------------------------------------------------------
package plhc_pkg;

    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 8;
    localparam int MS_W     = 16;
    localparam int LEVEL_W  = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEVEL_W-1:0] LVL_NORMAL   = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_MILD     = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_MODERATE = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_SEVERE   = 2'd3;

    localparam logic CMD_OBSERVE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ESCALATE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 8'd3;

    localparam logic [COUNT_W-1:0] ESCALATE_RESET = 8'd3;
    localparam logic [COUNT_W-1:0] RECOVER_RESET  = 8'd5;
    localparam logic [MS_W-1:0]    WINDOW_RESET   = 16'd1000;
    localparam logic [MS_W-1:0]    TIMEOUT_RESET  = 16'd3000;

    localparam logic [15:0] SEV_QUEUE   = 16'd12;
    localparam logic [15:0] SEV_DROPS   = 16'd10;
    localparam logic [15:0] SEV_ERRS    = 16'd10;
    localparam logic [23:0] SEV_RENDER  = 24'd40000;
    localparam logic [15:0] MOD_QUEUE   = 16'd8;
    localparam logic [15:0] MOD_DROPS   = 16'd4;
    localparam logic [23:0] MOD_RENDER  = 24'd28000;
    localparam logic [15:0] MILD_QUEUE  = 16'd4;
    localparam logic [23:0] MILD_RENDER = 24'd18000;
    localparam logic [23:0] MILD_SWAP   = 24'd16000;

    typedef struct packed {
        logic                cmd;
        logic [TIME_W-1:0]   now_ms;
        logic                decode_seen;
        logic                ingress_seen;
        logic [LEVEL_W-1:0]  obs_level;
    } item_t;

    typedef struct packed {
        logic                cfg_valid;
        logic [CFG_IDX_W-1:0]  cfg_index;
        logic [CFG_DATA_W-1:0] cfg_data;
    } cfg_wr_t;

    function automatic logic [LEVEL_W-1:0] classify(
        input logic [15:0] q,
        input logic [15:0] d,
        input logic [15:0] e,
        input logic [23:0] r,
        input logic [23:0] s
    );
        logic [LEVEL_W-1:0] lvl;
        if (q >= SEV_QUEUE || d >= SEV_DROPS || e >= SEV_ERRS || r >= SEV_RENDER) begin
            lvl = LVL_SEVERE;
        end else if (q >= MOD_QUEUE || d >= MOD_DROPS || r >= MOD_RENDER) begin
            lvl = LVL_MODERATE;
        end else if (q >= MILD_QUEUE || r >= MILD_RENDER || s >= MILD_SWAP) begin
            lvl = LVL_MILD;
        end else begin
            lvl = LVL_NORMAL;
        end
        return lvl;
    endfunction

endpackage

@@ hdl/plhc_front.sv @@
// ----------------------------------------------------------------------------
// plhc_front
// Input register stage that unpacks a request and classifies its window.
// ----------------------------------------------------------------------------
module plhc_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [plhc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tuser,
    output logic                           item_valid,
    input  logic                           item_ready,
    output plhc_pkg::item_t                item
);

    logic            valid_reg;
    logic            valid_next;
    plhc_pkg::item_t item_reg;
    plhc_pkg::item_t item_next;

    assign s_axis_tready = !valid_reg || item_ready;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_comb begin
        item_next.cmd          = s_axis_tuser;
        item_next.now_ms       = s_axis_tdata[31:0];
        item_next.decode_seen  = s_axis_tdata[32];
        item_next.ingress_seen = s_axis_tdata[33];
        item_next.obs_level    = plhc_pkg::classify(s_axis_tdata[49:34], s_axis_tdata[65:50],
                                                    s_axis_tdata[81:66], s_axis_tdata[105:82],
                                                    s_axis_tdata[129:106]);
        valid_next = valid_reg;
        if (s_axis_tready) begin
            valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            item_reg <= item_next;
        end
    end

endmodule

@@ hdl/plhc_queue.sv @@
// ----------------------------------------------------------------------------
// plhc_queue
// Short first-in first-out queue of classified requests.
// ----------------------------------------------------------------------------
module plhc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  plhc_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output plhc_pkg::item_t pop_item,
    output logic [plhc_pkg::QCNT_W-1:0] fill
);

    plhc_pkg::item_t                  slot_reg [plhc_pkg::QUEUE_DEPTH];
    logic [plhc_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [plhc_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [plhc_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [plhc_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [plhc_pkg::QCNT_W-1:0]      count_reg;
    logic [plhc_pkg::QCNT_W-1:0]      count_next;
    logic                             do_push;
    logic                             do_pop;

    assign push_ready = count_reg != plhc_pkg::QCNT_W'(plhc_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign fill       = count_reg;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == plhc_pkg::QPTR_W'(plhc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == plhc_pkg::QPTR_W'(plhc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hdl/plhc_back.sv @@
// ----------------------------------------------------------------------------
// plhc_back
// Level state machine with configuration registers and output register.
// ----------------------------------------------------------------------------
module plhc_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  plhc_pkg::cfg_wr_t              cfg_wr,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  plhc_pkg::item_t                item,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [plhc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tuser
);

    localparam int TW = plhc_pkg::TIME_W;
    localparam int CW = plhc_pkg::COUNT_W;
    localparam int LW = plhc_pkg::LEVEL_W;
    localparam int MW = plhc_pkg::MS_W;

    logic [CW-1:0] esc_cfg_reg;
    logic [CW-1:0] rec_cfg_reg;
    logic [MW-1:0] win_cfg_reg;
    logic [MW-1:0] tmo_cfg_reg;

    logic [LW-1:0] level_reg,   level_next;
    logic [CW-1:0] over_reg,    over_next;
    logic [CW-1:0] clean_reg,   clean_next;
    logic          started_reg, started_next;
    logic          seen_reg,    seen_next;
    logic          tflag_reg,   tflag_next;
    logic [TW-1:0] wstart_reg,  wstart_next;
    logic [TW-1:0] ltel_reg,    ltel_next;
    logic [TW-1:0] entered_reg, entered_next;

    logic          out_valid_reg, out_valid_next;
    logic [plhc_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic          out_user_reg;

    logic [CW-1:0] esc;
    logic [CW-1:0] rec;
    logic [MW-1:0] win;
    logic [MW-1:0] tmo;
    logic [TW-1:0] ws_eff;
    logic [TW-1:0] lt_eff;
    logic [TW-1:0] le_eff;
    logic [TW-1:0] now_obs;
    logic [TW-1:0] now_tick;
    logic [CW-1:0] over_inc;
    logic [CW-1:0] clean_inc;
    logic          due;
    logic          tel_ok;
    logic          tout;
    logic          take;

    assign take          = item_valid && item_ready;
    assign item_ready    = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    always_comb begin
        esc = (esc_cfg_reg == '0) ? CW'(1) : esc_cfg_reg;
        rec = (rec_cfg_reg == '0) ? CW'(1) : rec_cfg_reg;
        win = (win_cfg_reg == '0) ? MW'(1) : win_cfg_reg;
        tmo = (tmo_cfg_reg < win) ? win : tmo_cfg_reg;

        due = !started_reg || item.now_ms < wstart_reg ||
              (item.now_ms - wstart_reg) >= TW'(win);

        ws_eff = started_reg ? wstart_reg  : item.now_ms;
        lt_eff = started_reg ? ltel_reg    : item.now_ms;
        le_eff = started_reg ? entered_reg : item.now_ms;
        now_obs  = (item.now_ms < ws_eff)   ? ws_eff   : item.now_ms;
        now_tick = (item.now_ms < ltel_reg) ? ltel_reg : item.now_ms;
        over_inc  = (over_reg < esc)  ? over_reg + 1'b1  : over_reg;
        clean_inc = (clean_reg < rec) ? clean_reg + 1'b1 : clean_reg;

        level_next   = level_reg;
        over_next    = over_reg;
        clean_next   = clean_reg;
        started_next = 1'b1;
        seen_next    = seen_reg;
        tflag_next   = tflag_reg;
        wstart_next  = ws_eff;
        ltel_next    = lt_eff;
        entered_next = le_eff;
        tel_ok       = 1'b0;
        tout         = 1'b0;

        if (item.cmd == plhc_pkg::CMD_TICK) begin
            if (started_reg) begin
                if ((now_tick - ltel_reg) >= TW'(tmo)) begin
                    tflag_next = 1'b1;
                end
                tel_ok = seen_reg && !tflag_next;
                tout   = tflag_next;
            end
        end else begin
            wstart_next = now_obs;
            if (!item.decode_seen) begin
                if ((now_obs - lt_eff) >= TW'(tmo)) begin
                    tflag_next = 1'b1;
                    if (item.ingress_seen && level_reg != plhc_pkg::LVL_SEVERE) begin
                        level_next   = plhc_pkg::LVL_SEVERE;
                        entered_next = now_obs;
                    end
                end
                tout = tflag_next;
            end else begin
                seen_next  = 1'b1;
                tflag_next = 1'b0;
                ltel_next  = now_obs;
                tel_ok     = 1'b1;
                if (item.obs_level != plhc_pkg::LVL_NORMAL) begin
                    clean_next = '0;
                    over_next  = over_inc;
                    if (over_inc >= esc) begin
                        over_next = '0;
                        if (item.obs_level > level_reg) begin
                            level_next   = item.obs_level;
                            entered_next = now_obs;
                        end
                    end
                end else begin
                    over_next = '0;
                    if (level_reg == plhc_pkg::LVL_NORMAL ||
                        (now_obs - le_eff) < TW'(win)) begin
                        clean_next = '0;
                    end else begin
                        clean_next = clean_inc;
                        if (clean_inc >= rec) begin
                            clean_next   = '0;
                            level_next   = level_reg - 1'b1;
                            entered_next = now_obs;
                        end
                    end
                end
            end
        end

        out_valid_next = out_valid_reg;
        if (item_ready) begin
            out_valid_next = item_valid;
        end
        out_data_next = {2'b00, due, tout, tel_ok, level_next != level_reg, level_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_cfg_reg   <= plhc_pkg::ESCALATE_RESET;
            rec_cfg_reg   <= plhc_pkg::RECOVER_RESET;
            win_cfg_reg   <= plhc_pkg::WINDOW_RESET;
            tmo_cfg_reg   <= plhc_pkg::TIMEOUT_RESET;
            level_reg     <= plhc_pkg::LVL_NORMAL;
            over_reg      <= '0;
            clean_reg     <= '0;
            started_reg   <= 1'b0;
            seen_reg      <= 1'b0;
            tflag_reg     <= 1'b0;
            wstart_reg    <= '0;
            ltel_reg      <= '0;
            entered_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cfg_wr.cfg_valid) begin
                case (cfg_wr.cfg_index)
                    plhc_pkg::REG_ESCALATE: esc_cfg_reg <= cfg_wr.cfg_data[CW-1:0];
                    plhc_pkg::REG_RECOVER:  rec_cfg_reg <= cfg_wr.cfg_data[CW-1:0];
                    plhc_pkg::REG_WINDOW:   win_cfg_reg <= cfg_wr.cfg_data;
                    plhc_pkg::REG_TIMEOUT:  tmo_cfg_reg <= cfg_wr.cfg_data;
                    default: begin
                    end
                endcase
            end
            if (take) begin
                level_reg   <= level_next;
                over_reg    <= over_next;
                clean_reg   <= clean_next;
                started_reg <= started_next;
                seen_reg    <= seen_next;
                tflag_reg   <= tflag_next;
                wstart_reg  <= wstart_next;
                ltel_reg    <= ltel_next;
                entered_reg <= entered_next;
            end
        end
        if (take) begin
            out_data_reg <= out_data_next;
            out_user_reg <= (item.cmd == plhc_pkg::CMD_OBSERVE);
        end
    end

endmodule

@@ hdl/pressure_level_hysteresis_controller_unit.sv @@
// ----------------------------------------------------------------------------
// pressure_level_hysteresis_controller_unit
// Pressure level controller with hysteresis, timeout and a classify front end.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                      Moves
//  s_axis    in         s_axis_tvalid / s_axis_tready  one observe or tick request
//  m_axis    out        m_axis_tvalid / m_axis_tready  one result per request
//  cfg       in         cfg_valid / cfg_ready          one register write
//
// From acceptance to result a request passes the input register and
// classification, the queue, and the level update into the output register.
// One request is taken per cycle while m_axis_tready does not stall the output.
// The queue lets the input side keep accepting while a result waits, until full.
// Reset clears levels, counters and timestamps and loads the register defaults.
// ----------------------------------------------------------------------------
module pressure_level_hysteresis_controller_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // now_ms[31:0], decode_seen[32], ingress_seen[33], queue_max[49:34],
    // drop_count[65:50], error_count[81:66], render_max_us[105:82],
    // swap_max_us[129:106], zero padding[135:130]
    input  logic [plhc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // cmd[0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // level[1:0], changed[2], telemetry_ok[3], timed_out[4], window_due[5],
    // zero padding[7:6]
    output logic [plhc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // from_observe[0]
    output logic                             m_axis_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [plhc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [plhc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                         front_valid;
    logic                         front_ready;
    plhc_pkg::item_t              front_item;
    logic                         queue_valid;
    logic                         queue_ready;
    plhc_pkg::item_t              queue_item;
    logic [plhc_pkg::QCNT_W-1:0]  queue_fill;
    plhc_pkg::cfg_wr_t            cfg_wr;

    assign cfg_ready        = 1'b1;
    assign cfg_wr.cfg_valid = cfg_valid && cfg_ready;
    assign cfg_wr.cfg_index = cfg_index;
    assign cfg_wr.cfg_data  = cfg_data;

    plhc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (front_valid),
        .item_ready    (front_ready),
        .item          (front_item)
    );

    plhc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item),
        .fill       (queue_fill)
    );

    plhc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr        (cfg_wr),
        .item_valid    (queue_valid),
        .item_ready    (queue_ready),
        .item          (queue_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_tick_keeps_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> !m_axis_tdata[2])
        else $error("a tick result reports a level change");

    a_ok_excludes_timeout: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[4]))
        else $error("telemetry reported healthy while timed out");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        queue_fill <= plhc_pkg::QCNT_W'(plhc_pkg::QUEUE_DEPTH))
        else $error("queue fill exceeds its depth");

    a_stall_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> front_valid && !front_ready)
        else $error("input stalled without a held request");

    a_change_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[2] && m_axis_tdata[1:0] != plhc_pkg::LVL_SEVERE
        |-> m_axis_tdata[3])
        else $error("level change below severe without decode telemetry");

endmodule
